// ----- hdl/sep_pkg.sv -----
// Shared types, constants and rounding helpers for the planar pose-error Jacobian block.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps
`default_nettype none

package sep_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int NUM_CELLS     = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629714;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [47:0] ONE_Q16     = 48'sd65536;

    localparam logic [1:0] ROW0 = 2'd0;
    localparam logic [1:0] ROW1 = 2'd1;
    localparam logic [1:0] ROW2 = 2'd2;

    typedef struct packed {
        logic signed [31:0] p1_x;
        logic signed [31:0] p1_y;
        logic signed [15:0] p1_angle;
        logic signed [31:0] p2_x;
        logic signed [31:0] p2_y;
        logic signed [15:0] constraint_angle;
    } pose_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [47:0] first_col0;
        logic signed [47:0] first_col1;
        logic signed [47:0] first_col2;
        logic signed [47:0] second_col0;
        logic signed [47:0] second_col1;
        logic signed [47:0] second_col2;
        logic               last_row;
    } rows_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               neg;
    } rot_t;

    typedef struct packed {
        rot_t               a1;
        rot_t               ad;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
    } chain_t;

    function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
        logic signed [31:0] r;
        begin
            case (idx)
                5'd0:    r = 32'sd210828714;
                5'd1:    r = 32'sd124459457;
                5'd2:    r = 32'sd65760959;
                5'd3:    r = 32'sd33381290;
                5'd4:    r = 32'sd16755422;
                5'd5:    r = 32'sd8385879;
                5'd6:    r = 32'sd4193963;
                5'd7:    r = 32'sd2097109;
                5'd8:    r = 32'sd1048571;
                5'd9:    r = 32'sd524287;
                5'd10:   r = 32'sd262144;
                5'd11:   r = 32'sd131072;
                5'd12:   r = 32'sd65536;
                5'd13:   r = 32'sd32768;
                5'd14:   r = 32'sd16384;
                5'd15:   r = 32'sd8192;
                5'd16:   r = 32'sd4096;
                5'd17:   r = 32'sd2048;
                5'd18:   r = 32'sd1024;
                5'd19:   r = 32'sd512;
                5'd20:   r = 32'sd256;
                5'd21:   r = 32'sd128;
                5'd22:   r = 32'sd64;
                5'd23:   r = 32'sd32;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

    // round half away from zero, shift 16, clamp to +-1.0 in Q1.14
    function automatic logic signed [15:0] rnd16_clamp(input logic signed [31:0] v);
        logic signed [32:0] w;
        logic signed [32:0] t;
        begin
            w = {v[31], v};
            if (!v[31])
                t = (w + 33'sd32768) >>> 16;
            else
                t = -((-w + 33'sd32768) >>> 16);
            if (t > 33'sd16384)
                t = 33'sd16384;
            else if (t < -33'sd16384)
                t = -33'sd16384;
            return t[15:0];
        end
    endfunction

    function automatic logic signed [19:0] rnd12(input logic signed [31:0] v);
        logic signed [32:0] w;
        logic signed [32:0] t;
        begin
            w = {v[31], v};
            if (!v[31])
                t = (w + 33'sd2048) >>> 12;
            else
                t = -((-w + 33'sd2048) >>> 12);
            return t[19:0];
        end
    endfunction

    function automatic logic signed [37:0] rnd28(input logic signed [65:0] v);
        logic signed [66:0] w;
        logic signed [66:0] t;
        begin
            w = {v[65], v};
            if (!v[65])
                t = (w + 67'sd134217728) >>> 28;
            else
                t = -((-w + 67'sd134217728) >>> 28);
            return t[37:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/se2_pose_error_jacobians.sv -----
// Top level: heading wrap/fold, chain of CORDIC cells, Jacobian terms and row output.
// Depends on sep_pkg, sep_cordic_cell, sep_jac.
//
//   channel | dir | word   | handshake
//   pose    | in  | pose_t | pose_valid / pose_stall
//   rows    | out | rows_t | rows_valid / rows_stall
//
// Path: NUM_CELLS (16) chain cells, then the f1, f2, f3 and row registers before the first row.
// Each pose word gives three row words; a new pose enters the single output row
// register only after its last row has been taken.
// Reset clears all valid flags and the row counter.
// A stalled row holds the whole pipeline once its tail stage is full.
`timescale 1ns / 1ps
`default_nettype none

module se2_pose_error_jacobians (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sep_pkg::pose_t pose,
    input  wire logic           pose_valid,
    output logic                pose_stall,
    output sep_pkg::rows_t      rows,
    output logic                rows_valid,
    input  wire logic           rows_stall
);

    logic            adv;
    logic            cv [sep_pkg::NUM_CELLS + 1];
    sep_pkg::chain_t cd [sep_pkg::NUM_CELLS + 1];
    sep_pkg::chain_t head;

    function automatic sep_pkg::rot_t fold(input logic signed [15:0] a);
        sep_pkg::rot_t r;
        logic signed [31:0] z;
        begin
            z = {a[15], a, 15'd0};
            if (z > sep_pkg::PI_Q28)
                z = z - sep_pkg::TWO_PI_Q28;
            else if (z < -sep_pkg::PI_Q28)
                z = z + sep_pkg::TWO_PI_Q28;
            r.neg = 1'b0;
            if (z > sep_pkg::HALF_PI_Q28)
            begin
                z     = z - sep_pkg::PI_Q28;
                r.neg = 1'b1;
            end
            else if (z < -sep_pkg::HALF_PI_Q28)
            begin
                z     = z + sep_pkg::PI_Q28;
                r.neg = 1'b1;
            end
            r.x = sep_pkg::GAIN_Q30;
            r.y = '0;
            r.z = z;
            return r;
        end
    endfunction

    always_comb
    begin
        head.a1 = fold(pose.p1_angle);
        head.ad = fold(pose.constraint_angle);
        head.dx = {pose.p2_x[31], pose.p2_x} - {pose.p1_x[31], pose.p1_x};
        head.dy = {pose.p2_y[31], pose.p2_y} - {pose.p1_y[31], pose.p1_y};
    end

    assign cv[0] = pose_valid;
    assign cd[0] = head;

    for (genvar i = 0; i < sep_pkg::NUM_CELLS; i++)
    begin : g_cell
        sep_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (cv[i]),
            .in_data   (cd[i]),
            .shift     (5'(i)),
            .atan      (sep_pkg::atan_q28(5'(i))),
            .out_valid (cv[i + 1]),
            .out_data  (cd[i + 1])
        );
    end

    sep_jac u_jac (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cv[sep_pkg::NUM_CELLS]),
        .in_data    (cd[sep_pkg::NUM_CELLS]),
        .adv        (adv),
        .rows       (rows),
        .rows_valid (rows_valid),
        .rows_stall (rows_stall)
    );

    assign pose_stall = !adv;

    a_take_first: assert property (@(posedge clk) disable iff (!rst_n)
        (pose_valid && !pose_stall) |=> cv[1])
        else $error("accepted pose not in chain");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        pose_stall |=> $stable(cv[1]))
        else $error("chain moved while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rows_valid && rows.last_row) |-> (rows.second_col2 == sep_pkg::ONE_Q16))
        else $error("bad last row");

endmodule

`default_nettype wire

// ----- hdl/sep_cordic_cell.sv -----
// One CORDIC rotation cell, applied to both headings at once; forwards the position deltas.
// Depends on sep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sep_cordic_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire sep_pkg::chain_t    in_data,
    input  wire logic [4:0]         shift,
    input  wire logic signed [31:0] atan,
    output logic                    out_valid,
    output sep_pkg::chain_t         out_data
);

    logic            valid_reg;
    sep_pkg::chain_t data_reg;
    sep_pkg::chain_t data_next;

    function automatic sep_pkg::rot_t rotate(input sep_pkg::rot_t r,
                                             input logic [4:0] sh,
                                             input logic signed [31:0] at);
        sep_pkg::rot_t o;
        logic signed [31:0] ddx;
        logic signed [31:0] ddy;
        begin
            ddx = r.y >>> sh;
            ddy = r.x >>> sh;
            o.neg = r.neg;
            if (!r.z[31])
            begin
                o.x = r.x - ddx;
                o.y = r.y + ddy;
                o.z = r.z - at;
            end
            else
            begin
                o.x = r.x + ddx;
                o.y = r.y - ddy;
                o.z = r.z + at;
            end
            return o;
        end
    endfunction

    always_comb
    begin
        data_next    = in_data;
        data_next.a1 = rotate(in_data.a1, shift, atan);
        data_next.ad = rotate(in_data.ad, shift, atan);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- hdl/sep_jac.sv -----
// Sine/cosine rounding, K-premultiplied Jacobian terms and the three-row output register.
// Depends on sep_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sep_jac (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire sep_pkg::chain_t in_data,
    output logic                 adv,
    output sep_pkg::rows_t       rows,
    output logic                 rows_valid,
    input  wire logic            rows_stall
);

    // f1: sin/cos
    logic                f1_valid_reg;
    logic signed [15:0]  c_reg, s_reg, cd_reg, sd_reg;
    logic signed [32:0]  f1_dx_reg, f1_dy_reg;
    logic signed [15:0]  c_next, s_next, cd_next, sd_next;
    // f2: P = cd*c + sd*s, Q = cd*s - sd*c
    logic                f2_valid_reg;
    logic signed [31:0]  p_reg, q_reg;
    logic signed [32:0]  f2_dx_reg, f2_dy_reg;
    logic signed [31:0]  p_next, q_next;
    // f3: position products
    logic                f3_valid_reg;
    logic signed [64:0]  qdx_reg, pdy_reg, pdx_reg, qdy_reg;
    logic signed [19:0]  pr_reg, qr_reg;
    // word register
    logic                emit_valid_reg;
    logic [1:0]          row_reg;
    logic signed [19:0]  ep_reg, eq_reg;
    logic signed [37:0]  a0_reg, a1_reg;
    logic signed [65:0]  a0_sum, a1_sum;
    logic                load;
    logic signed [47:0]  pe, qe, a0e, a1e;

    always_comb
    begin
        c_next  = sep_pkg::rnd16_clamp(in_data.a1.x);
        s_next  = sep_pkg::rnd16_clamp(in_data.a1.y);
        cd_next = sep_pkg::rnd16_clamp(in_data.ad.x);
        sd_next = sep_pkg::rnd16_clamp(in_data.ad.y);
        if (in_data.a1.neg)
        begin
            c_next = -c_next;
            s_next = -s_next;
        end
        if (in_data.ad.neg)
        begin
            cd_next = -cd_next;
            sd_next = -sd_next;
        end
        p_next = cd_reg * c_reg + sd_reg * s_reg;
        q_next = cd_reg * s_reg - sd_reg * c_reg;
    end

    assign load = !emit_valid_reg || (!rows_stall && row_reg == sep_pkg::ROW2);
    assign adv  = !f3_valid_reg || load;

    assign a0_sum = {pdy_reg[64], pdy_reg} - {qdx_reg[64], qdx_reg};
    assign a1_sum = -{pdx_reg[64], pdx_reg} - {qdy_reg[64], qdy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg   <= 1'b0;
            f2_valid_reg   <= 1'b0;
            f3_valid_reg   <= 1'b0;
            emit_valid_reg <= 1'b0;
            row_reg        <= sep_pkg::ROW0;
        end
        else
        begin
            if (adv)
            begin
                f1_valid_reg <= in_valid;
                f2_valid_reg <= f1_valid_reg;
                f3_valid_reg <= f2_valid_reg;
            end
            if (load)
            begin
                emit_valid_reg <= f3_valid_reg;
                row_reg        <= sep_pkg::ROW0;
            end
            else if (!rows_stall)
                row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg     <= c_next;
            s_reg     <= s_next;
            cd_reg    <= cd_next;
            sd_reg    <= sd_next;
            f1_dx_reg <= in_data.dx;
            f1_dy_reg <= in_data.dy;
            p_reg     <= p_next;
            q_reg     <= q_next;
            f2_dx_reg <= f1_dx_reg;
            f2_dy_reg <= f1_dy_reg;
            qdx_reg   <= q_reg * f2_dx_reg;
            pdy_reg   <= p_reg * f2_dy_reg;
            pdx_reg   <= p_reg * f2_dx_reg;
            qdy_reg   <= q_reg * f2_dy_reg;
            pr_reg    <= sep_pkg::rnd12(p_reg);
            qr_reg    <= sep_pkg::rnd12(q_reg);
        end
        if (load)
        begin
            ep_reg <= pr_reg;
            eq_reg <= qr_reg;
            a0_reg <= sep_pkg::rnd28(a0_sum);
            a1_reg <= sep_pkg::rnd28(a1_sum);
        end
    end

    assign pe  = {{28{ep_reg[19]}}, ep_reg};
    assign qe  = {{28{eq_reg[19]}}, eq_reg};
    assign a0e = {{10{a0_reg[37]}}, a0_reg};
    assign a1e = {{10{a1_reg[37]}}, a1_reg};

    always_comb
    begin
        rows.row_index = row_reg;
        rows.last_row  = (row_reg == sep_pkg::ROW2);
        case (row_reg)
            sep_pkg::ROW0:
            begin
                rows.first_col0  = -pe;
                rows.first_col1  = -qe;
                rows.first_col2  = a0e;
                rows.second_col0 = pe;
                rows.second_col1 = qe;
                rows.second_col2 = '0;
            end
            sep_pkg::ROW1:
            begin
                rows.first_col0  = qe;
                rows.first_col1  = -pe;
                rows.first_col2  = a1e;
                rows.second_col0 = -qe;
                rows.second_col1 = pe;
                rows.second_col2 = '0;
            end
            default:
            begin
                rows.first_col0  = '0;
                rows.first_col1  = '0;
                rows.first_col2  = -sep_pkg::ONE_Q16;
                rows.second_col0 = '0;
                rows.second_col1 = '0;
                rows.second_col2 = sep_pkg::ONE_Q16;
            end
        endcase
    end

    assign rows_valid = emit_valid_reg;

    a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (rows_valid && !rows_stall && row_reg != sep_pkg::ROW2)
        |=> (rows_valid && row_reg == $past(row_reg) + 2'd1))
        else $error("row sequence broken");

    a_row_code: assert property (@(posedge clk) disable iff (!rst_n)
        rows_valid |-> (row_reg == sep_pkg::ROW0 || row_reg == sep_pkg::ROW1
                        || row_reg == sep_pkg::ROW2))
        else $error("bad row code");

    a_row0_sym: assert property (@(posedge clk) disable iff (!rst_n)
        (rows_valid && row_reg == sep_pkg::ROW0)
        |-> (rows.first_col0 == -rows.second_col0))
        else $error("row 0 symmetry broken");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        (f3_valid_reg && !load) |=> (f3_valid_reg && $stable(pr_reg)))
        else $error("pending item lost");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for se2_pose_error_jacobians: drives pose words, predicts the three
// Jacobian row words per pose in SystemVerilog and checks them. Depends on sep_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

    logic            clk = 1'b0;
    logic            rst_n;
    sep_pkg::pose_t  pose;
    logic            pose_valid;
    logic            pose_stall;
    sep_pkg::rows_t  rows;
    logic            rows_valid;
    logic            rows_stall;

    sep_pkg::pose_t  pending_poses[$];
    sep_pkg::rows_t  expected_rows[$];
    int     mismatches = 0;
    int     idle_pct;
    int     stall_pct;
    int     hold_cycles;
    bit     hold_req;
    bit     hold_done;

    localparam longint OUT_MAX = 64'sd140737488355327;
    localparam longint OUT_MIN = -64'sd140737488355328;
    localparam longint ATANS[24] = '{210828714, 124459457, 65760959, 33381290,
        16755422, 8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

    se2_pose_error_jacobians DUT (
        .clk(clk), .rst_n(rst_n), .pose(pose), .pose_valid(pose_valid),
        .pose_stall(pose_stall), .rows(rows), .rows_valid(rows_valid),
        .rows_stall(rows_stall)
    );

    always #2 clk = ~clk;

    function automatic longint round_shift(longint v, int s);
        longint h;
        h = 64'sd1 <<< (s - 1);
        if (v >= 0)
            return (v + h) >>> s;
        return -((-v + h) >>> s);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic heading_trig(input logic signed [15:0] a, output longint co,
                                output longint si);
        longint z, x, y, tx, ty;
        bit     flip;
        int     n;
        z = longint'(a) * 32768;
        x = 652032874;
        y = 0;
        flip = 0;
        n = sep_pkg::CORDIC_STAGES > 24 ? 24 : sep_pkg::CORDIC_STAGES;
        if (z > 843314857) z -= 2 * 843314857;
        else if (z < -843314857) z += 2 * 843314857;
        if (z > 421657428)
        begin
            z -= 843314857;
            flip = 1;
        end
        else if (z < -421657428)
        begin
            z += 843314857;
            flip = 1;
        end
        for (int i = 0; i < n; i++)
        begin
            tx = y >>> i;
            ty = x >>> i;
            if (z >= 0)
            begin
                x -= tx;
                y += ty;
                z -= ATANS[i];
            end
            else
            begin
                x += tx;
                y -= ty;
                z += ATANS[i];
            end
        end
        x = clip(round_shift(x, 16), -16384, 16384);
        y = clip(round_shift(y, 16), -16384, 16384);
        co = flip ? -x : x;
        si = flip ? -y : y;
    endtask

    task automatic predict_jacobian_rows(input sep_pkg::pose_t p);
        longint c, s, cd, sd, dx, dy, v;
        longint m[2][3][3];
        sep_pkg::rows_t r;
        heading_trig(p.p1_angle, c, s);
        heading_trig(p.constraint_angle, cd, sd);
        dx = longint'(p.p2_x) - longint'(p.p1_x);
        dy = longint'(p.p2_y) - longint'(p.p1_y);
        m[0][0][0] = -c * 65536; m[0][0][1] = -s * 65536; m[0][0][2] = -s * dx + c * dy;
        m[0][1][0] = s * 65536;  m[0][1][1] = -c * 65536; m[0][1][2] = -c * dx - s * dy;
        m[0][2][0] = 0;          m[0][2][1] = 0;          m[0][2][2] = -1073741824;
        m[1][0][0] = c * 65536;  m[1][0][1] = s * 65536;  m[1][0][2] = 0;
        m[1][1][0] = -s * 65536; m[1][1][1] = c * 65536;  m[1][1][2] = 0;
        m[1][2][0] = 0;          m[1][2][1] = 0;          m[1][2][2] = 1073741824;
        for (int row = 0; row < 3; row++)
        begin
            logic signed [47:0] e[6];
            for (int k = 0; k < 2; k++)
                for (int j = 0; j < 3; j++)
                begin
                    if (row == 0) v = cd * m[k][0][j] - sd * m[k][1][j];
                    else if (row == 1) v = sd * m[k][0][j] + cd * m[k][1][j];
                    else v = 16384 * m[k][2][j];
                    e[k * 3 + j] = 48'(clip(round_shift(v, 28), OUT_MIN, OUT_MAX));
                end
            r.row_index = row == 0 ? sep_pkg::ROW0 : (row == 1 ? sep_pkg::ROW1 : sep_pkg::ROW2);
            r.first_col0 = e[0]; r.first_col1 = e[1]; r.first_col2 = e[2];
            r.second_col0 = e[3]; r.second_col1 = e[4]; r.second_col2 = e[5];
            r.last_row = (row == 2);
            expected_rows.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic sep_pkg::pose_t random_pose(int mode);
        sep_pkg::pose_t p;
        p.p1_x = $urandom; p.p1_y = $urandom; p.p2_x = $urandom; p.p2_y = $urandom;
        p.p1_angle = 16'($urandom);
        p.constraint_angle = 16'($urandom);
        if (mode < 6)
        begin
            p.p1_angle = 16'($urandom_range(0, 51472) - 25736);
            p.constraint_angle = 16'($urandom_range(0, 51472) - 25736);
        end
        if (mode < 3)
        begin
            p.p2_x = p.p1_x + 32'($urandom_range(0, 1 << 24)) - (1 << 23);
            p.p2_y = p.p1_y + 32'($urandom_range(0, 1 << 24)) - (1 << 23);
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_valid <= 1'b0;
            pose <= '0;
        end
        else if (!pose_valid || !pose_stall)
        begin
            if (pending_poses.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                pose <= pending_poses[0];
                predict_jacobian_rows(pending_poses.pop_front());
                pose_valid <= 1'b1;
            end
            else
                pose_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_stall <= 1'b0;
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            rows_stall <= 1'b1;
            hold_cycles <= 199;
            hold_done <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            rows_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            rows_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        sep_pkg::rows_t w;
        if (rst_n && rows_valid && !rows_stall)
        begin
            if (expected_rows.size() == 0)
                report_mismatch("unexpected word", 0, 0);
            else
            begin
                w = expected_rows.pop_front();
                if (rows.row_index !== w.row_index)
                    report_mismatch("row_index", rows.row_index, w.row_index);
                if (rows.first_col0 !== w.first_col0)
                    report_mismatch("first_col0", rows.first_col0, w.first_col0);
                if (rows.first_col1 !== w.first_col1)
                    report_mismatch("first_col1", rows.first_col1, w.first_col1);
                if (rows.first_col2 !== w.first_col2)
                    report_mismatch("first_col2", rows.first_col2, w.first_col2);
                if (rows.second_col0 !== w.second_col0)
                    report_mismatch("second_col0", rows.second_col0, w.second_col0);
                if (rows.second_col1 !== w.second_col1)
                    report_mismatch("second_col1", rows.second_col1, w.second_col1);
                if (rows.second_col2 !== w.second_col2)
                    report_mismatch("second_col2", rows.second_col2, w.second_col2);
                if (rows.last_row !== w.last_row)
                    report_mismatch("last_row", rows.last_row, w.last_row);
            end
        end
    end

    task automatic drain();
        while (pending_poses.size() > 0 || pose_valid || expected_rows.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        sep_pkg::pose_t p;
        logic signed [15:0] angs[8];
        logic signed [31:0] pos[4];
        rst_n = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        angs = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
                 16'sh7fff, 16'sh8000, 16'sd13000};
        pos = '{32'sh7fffffff, 32'sh80000000, 32'sd0, 32'sd65536};
        repeat (2) @(posedge clk);
        rst_n <= 1;
        for (int i = 0; i < 8; i++)
        begin
            p.p1_x = pos[i % 4]; p.p1_y = pos[(i + 1) % 4];
            p.p2_x = pos[(i + 1) % 4]; p.p2_y = pos[i % 4];
            p.p1_angle = angs[i]; p.constraint_angle = angs[7 - i];
            pending_poses.push_back(p);
        end
        for (int i = 0; i < 8; i++)
        begin
            p = random_pose(9);
            p.p1_angle = angs[i]; p.constraint_angle = angs[(i + 3) % 8];
            if (i < 4)
            begin
                p.p1_x = 32'sh80000000; p.p2_x = 32'sh7fffffff;
                p.p1_y = 32'sh7fffffff; p.p2_y = 32'sh80000000;
            end
            pending_poses.push_back(p);
        end
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = ph == 1 || ph == 3 ? (ph == 1 ? 58 : 34) : 0;
            stall_pct = ph == 2 ? 58 : (ph == 3 ? 34 : 0);
            for (int i = 0; i < 36; i++)
                pending_poses.push_back(random_pose($urandom_range(0, 9)));
            if (ph == 0)
                hold_req = 1;
            drain();
        end
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- se2_pose_error_jacobians.f -----
hdl/sep_pkg.sv
hdl/sep_cordic_cell.sv
hdl/sep_jac.sv
hdl/se2_pose_error_jacobians.sv
test/testbench.sv
